// File: rtl/gcbr_pkg.sv
`default_nettype none
package gcbr_pkg;

   localparam int LEVEL_BITS_DEF = 8;
   localparam int CONTRAST_W     = 16;
   localparam int BRIGHT_W       = 17;
   localparam int INV_GAMMA_W    = 14;
   localparam int RAMP_W         = 16;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 17;
   localparam int TAB_W          = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_CONTRAST      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_GAMMA = 2'd2;

   typedef logic [TAB_W-1:0] tab_type [0:256];

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] bt;
      v  = v_in;
      r  = '0;
      bt = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bt > v) bt = bt >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bt != 0) begin
            if (v >= r + bt) begin
               v = v - (r + bt);
               r = (r >> 1) + bt;
            end else begin
               r = r >> 1;
            end
            bt = bt >> 2;
         end
      end
      return r;
   endfunction

   // log2(1 + k/256), Q16; extra entry is 1.0
   function automatic tab_type make_log_tab();
      tab_type     t;
      logic [63:0] x;
      logic [31:0] r;
      for (int k = 0; k < 256; k++) begin
         x = 64'(256 + k) << 22;
         r = '0;
         for (int i = 0; i < 16; i++) begin
            x = (x * x) >> 30;
            r = r << 1;
            if (x >= (64'd2 << 30)) begin
               r = r | 32'd1;
               x = x >> 1;
            end
         end
         t[k] = TAB_W'(r);
      end
      t[256] = TAB_W'(65536);
      return t;
   endfunction

   // 2^(-k/256), Q16; extra entry is 0.5
   function automatic tab_type make_exp_tab();
      tab_type     t;
      logic [63:0] roots [0:7];
      logic [63:0] v;
      logic [63:0] p;
      logic [31:0] m;
      v = 64'd2 << 30;
      for (int i = 0; i < 8; i++) begin
         v = isqrt64(v << 30);
         roots[i] = v;
      end
      for (int k = 0; k < 256; k++) begin
         m = 32'(256 - k);
         p = 64'd1 << 30;
         if (m == 32'd256) begin
            p = 64'd2 << 30;
         end else begin
            for (int b = 0; b < 8; b++) begin
               if (m[b]) p = (p * roots[7-b]) >> 30;
            end
         end
         t[k] = TAB_W'((p + (64'd1 << 14)) >> 15);
      end
      t[256] = TAB_W'(32768);
      return t;
   endfunction

   localparam tab_type LOG_TAB = make_log_tab();
   localparam tab_type EXP_TAB = make_exp_tab();

   function automatic logic [31:0] const_log2(input logic [31:0] v);
      logic [31:0] p;
      logic [31:0] mant;
      logic [31:0] frac;
      logic [31:0] a;
      logic [31:0] b;
      p = '0;
      for (int i = 0; i < 32; i++) begin
         if (p < 31 && (v >> (p + 1)) != 0) p = p + 1;
      end
      if (p >= 16) mant = v >> (p - 16);
      else         mant = v << (16 - p);
      frac = mant - 32'd65536;
      a = 32'(LOG_TAB[frac[15:8]]);
      b = 32'(LOG_TAB[9'(frac[15:8]) + 9'd1]);
      return (p << 16) + a + (((b - a) * 32'(frac[7:0])) >> 8);
   endfunction

endpackage
`default_nettype wire

// File: rtl/gamma_contrast_brightness_ramp.sv
// channel | ports                      | payload
// req     | req_tvalid/tready/tdata    | level
// rsp     | rsp_tvalid/tready/tdata    | ramp_value
// csr     | csr_we/csr_index/csr_wdata | contrast, brightness, inverse_gamma
// One item per cycle while the output is not stalled, through six register
// stages. Table lookups and the exponent multiply set the stage depth.
// Synchronous reset clears the valid bits and loads register defaults.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
`default_nettype none
module gamma_contrast_brightness_ramp
   import gcbr_pkg::*;
#(
   parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [((LEVEL_BITS+7)/8)*8-1:0]       req_tdata,  // level
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic      [RAMP_W-1:0]                     rsp_tdata,  // ramp_value
   input  wire logic                                  csr_we,
   input  wire logic [CSR_INDEX_W-1:0]                csr_index,
   input  wire logic [CSR_DATA_W-1:0]                 csr_wdata
);

   localparam int CW   = LEVEL_BITS + 8;
   localparam int PW   = LEVEL_BITS + 19;
   localparam int PBW  = $clog2(CW);
   localparam int NW   = $clog2(CW + 1) + 16;
   localparam int TW   = NW + 2;
   localparam int MAXL = (1 << LEVEL_BITS) - 1;
   localparam int MID  = 1 << (LEVEL_BITS - 1);
   localparam logic [CW-1:0] MAXC = CW'(MAXL * 256);
   localparam logic [NW-1:0] LMAX = NW'(const_log2(32'(MAXL * 256)));

   logic [CONTRAST_W-1:0]  contrast_ff;
   logic [BRIGHT_W-1:0]    brightness_ff;
   logic [INV_GAMMA_W-1:0] inv_gamma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         contrast_ff   <= CONTRAST_W'(256);
         brightness_ff <= '0;
         inv_gamma_ff  <= INV_GAMMA_W'(4096);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CONTRAST:      contrast_ff   <= csr_wdata[CONTRAST_W-1:0];
            CSR_BRIGHTNESS:    brightness_ff <= csr_wdata[BRIGHT_W-1:0];
            CSR_INVERSE_GAMMA: inv_gamma_ff  <= csr_wdata[INV_GAMMA_W-1:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   assign en         = !v6_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = v6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff} <= '0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // stage 1: contrast and clamp
   logic signed [LEVEL_BITS:0] diff;
   logic signed [PW-1:0]       c_full;
   logic        [CW-1:0]       c_in, c_ff;
   always_comb begin
      diff   = $signed({1'b0, req_tdata[LEVEL_BITS-1:0]}) - $signed((LEVEL_BITS+1)'(MID));
      c_full = PW'(diff) * $signed(PW'(contrast_ff)) + $signed(PW'(MID * 256));
      if (c_full < 0)                           c_in = '0;
      else if (c_full > $signed(PW'(MAXC)))     c_in = MAXC;
      else                                      c_in = c_full[CW-1:0];
   end

   // stage 2: leading one and normalise
   logic [PBW-1:0] msb_in, msb_ff;
   logic [15:0]    frac_in, frac_ff;
   logic           zero2_ff;
   logic [CW+15:0] shifted;
   always_comb begin
      msb_in = '0;
      for (int i = 0; i < CW; i++) begin
         if (c_ff[i]) msb_in = PBW'(i);
      end
      shifted = (CW+16)'(c_ff) << (16 - 32'(msb_in) + CW);
      frac_in = shifted[CW+15:CW];
   end

   // stage 3: log interpolation and distance to full scale
   logic [TAB_W-1:0] la, lb;
   logic [TAB_W+7:0] ld;
   logic [NW-1:0]    lc;
   logic [NW-1:0]    n_in, n_ff;
   logic             zero3_ff;
   always_comb begin
      la = LOG_TAB[frac_ff[15:8]];
      lb = LOG_TAB[9'(frac_ff[15:8]) + 9'd1];
      ld = (TAB_W+8)'(lb - la) * (TAB_W+8)'(frac_ff[7:0]);
      lc = (NW'(msb_ff) << 16) + NW'(la) + NW'(ld >> 8);
      n_in = (LMAX > lc) ? LMAX - lc : '0;
   end

   // stage 4: exponent scaling
   logic [NW+INV_GAMMA_W-1:0] prod_e;
   logic [TW-1:0]             t_in, t_ff;
   logic                      zero4_ff;
   always_comb begin
      prod_e = (NW+INV_GAMMA_W)'(n_ff) * (NW+INV_GAMMA_W)'(inv_gamma_ff)
               + (NW+INV_GAMMA_W)'(2048);
      t_in   = TW'(prod_e >> 12);
   end

   // stage 5: exp2
   logic [TAB_W-1:0] p_in, p_ff;
   logic [TAB_W-1:0] p_raw;
   gcbr_exp2 #(.TW(TW)) u_exp2 (.t(t_ff), .p(p_raw));
   assign p_in = zero4_ff ? '0 : p_raw;

   // stage 6: scale, offset, saturate
   logic [33:0]        scaled;
   logic signed [18:0] sum;
   logic [RAMP_W-1:0]  ramp_in, ramp_ff;
   always_comb begin
      scaled = ((34'(p_ff) << 16) - 34'(p_ff) + 34'd32768) >> 16;
      sum    = $signed({1'b0, scaled[17:0]}) + 19'(signed'(brightness_ff));
      if (sum < 0)                       ramp_in = '0;
      else if (sum > 19'sd65535)         ramp_in = 16'hFFFF;
      else                               ramp_in = sum[RAMP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff     <= c_in;
         msb_ff   <= msb_in;
         frac_ff  <= frac_in;
         zero2_ff <= (c_ff == '0);
         n_ff     <= n_in;
         zero3_ff <= zero2_ff;
         t_ff     <= t_in;
         zero4_ff <= zero3_ff;
         p_ff     <= p_in;
         ramp_ff  <= ramp_in;
      end
   end

   assign rsp_tdata = ramp_ff;

`ifndef ASSERT_OFF
   a_ready_follows_out : assert property (@(posedge clock)
      req_tready == (!v6_ff || rsp_tready))
      else $error("ready does not follow output stage");
   a_empty_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
   a_pipe_advance : assert property (@(posedge clock) disable iff (reset)
      (v5_ff && en) |=> v6_ff)
      else $error("item lost between last stages");
`endif

endmodule
`default_nettype wire

// File: rtl/gcbr_exp2.sv
`default_nettype none
module gcbr_exp2
   import gcbr_pkg::*;
#(
   parameter int TW = 23
) (
   input  wire logic [TW-1:0]    t,
   output logic      [TAB_W-1:0] p
);

   logic [7:0]       idx;
   logic [7:0]       lo;
   logic [TAB_W-1:0] a;
   logic [TAB_W-1:0] b;
   logic [TAB_W+7:0] dl;
   logic [TAB_W-1:0] v;
   logic [TW-17:0]   ip;

   always_comb begin
      idx = t[15:8];
      lo  = t[7:0];
      ip  = t[TW-1:16];
      a   = EXP_TAB[idx];
      b   = EXP_TAB[9'(idx) + 9'd1];
      dl  = (TAB_W+8)'(a - b) * (TAB_W+8)'(lo);
      v   = a - TAB_W'(dl >> 8);
      if (ip >= (TW-16)'(17)) p = '0;
      else                    p = v >> ip;
   end

endmodule
`default_nettype wire
